// ===== design/wprq_pkg.sv =====
// ----------------------------------------------------------------------------
// wprq_pkg
// Types and constants shared by the windowed priority request queue.
// ----------------------------------------------------------------------------
package wprq_pkg;

  // Fixed field widths of the item payloads
  localparam int ModeW     = 2;
  localparam int TagFieldW = 16;
  localparam int RunW      = 64;
  localparam int ArrW      = 64;
  localparam int WinW      = 16;
  localparam int StatusW   = 2;
  localparam int OccW      = 6;

  // Arrival bucket: arrival time divided by BucketDiv
  localparam int BucketDiv   = 100;
  localparam int BucketW     = 58;   // 2**64 / 100 fits in 58 bits
  localparam int RemW        = 7;    // remainder below 100
  localparam int DivStepBits = 8;    // quotient bits resolved per cycle

  localparam logic [WinW-1:0] WindowReset = 16'd15;

  typedef enum logic [ModeW-1:0] {
    MODE_ADD      = 2'd0,
    MODE_DISPATCH = 2'd1,
    MODE_REMOVE   = 2'd2,
    MODE_NOP      = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_MISS = 2'd2
  } status_e;

  typedef struct packed {
    mode_e                mode;
    logic [TagFieldW-1:0] request_tag;
    logic [RunW-1:0]      virtual_runtime;
    logic [ArrW-1:0]      arrival_time;
  } in_item_t;

  typedef struct packed {
    logic                 out_valid;
    logic [TagFieldW-1:0] out_tag;
    status_e              status;
    logic [OccW-1:0]      occupancy;
  } out_item_t;

endpackage

// ===== design/windowed_priority_request_queue.sv =====
// ----------------------------------------------------------------------------
// windowed_priority_request_queue
// Ordered request queue held in one synchronous memory: add with windowed
// runtime ordering, dispatch of the head, removal by tag.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid_i / in_ready_o, in_item_i): one operation per item,
//     chosen by its mode field. One item is worked on at a time; in_ready_o
//     is high while the block is idle, also when a result still waits.
//   out channel (out_valid_o / out_ready_i, out_item_o): exactly one result
//     item per input item, in order, held in an output register.
//   cfg channel (cfg_valid_i / cfg_ready_o, cfg_data_i): writes the window in
//     buckets; always ready, write it only while the block is idle.
// Work per item, with N the entries held:
//   add      bucket divide; with N of 0 or 1 the item is appended, else the
//            entries from position 1 on are walked for one in the window
//            with a runtime no lower; the item goes to the tail if none is
//            found, else its slot is opened from the tail down
//   dispatch reads the head; remove walks to the tag and closes the gap above it;
//   full / empty / no-op go straight to the result.
//   The memory port visits one entry per cycle in the walk and the shift.
// Reset: the queue is empty, head at slot 0, window 15. The memory is not
//   cleared: only entries below the fill count are ever read.
// A stalled receiver holds the result in the output register; a finished
//   operation waits for it before the block goes idle again.
// ----------------------------------------------------------------------------
module windowed_priority_request_queue #(
  parameter int QUEUE_DEPTH = 32,
  parameter int TAG_BITS    = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  wprq_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output wprq_pkg::out_item_t             out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wprq_pkg::WinW-1:0]       cfg_data_i
);

  localparam int PtrW    = $clog2(QUEUE_DEPTH);
  localparam int CntW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SumW    = CntW + 1;
  localparam int OutTagW = wprq_pkg::TagFieldW;
  localparam int StTagW  = (TAG_BITS < OutTagW) ? TAG_BITS : OutTagW;
  localparam int RunW    = wprq_pkg::RunW;
  localparam int BucketW = wprq_pkg::BucketW;
  localparam int OccW    = wprq_pkg::OccW;
  localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(QUEUE_DEPTH - 1);

  typedef struct packed {
    logic [StTagW-1:0]  tag;
    logic [RunW-1:0]    runtime;
    logic [BucketW-1:0] bucket;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_SHIFT,
    S_INS,
    S_POP,
    S_POPD,
    S_DONE
  } state_e;

  state_e                  state_q;
  logic [CntW-1:0]         count_q;
  logic [PtrW-1:0]         head_q;
  logic [wprq_pkg::WinW-1:0] window_q;

  // operation being worked on
  wprq_pkg::mode_e         mode_q;
  logic [StTagW-1:0]       new_tag_q;
  logic [RunW-1:0]         new_runtime_q;
  logic [BucketW-1:0]      new_bucket_q;

  // walk and shift control
  logic [CntW-1:0]         rd_idx_q;
  logic                    rd_act_q;
  logic                    dv_q;
  logic [CntW-1:0]         chk_idx_q;
  logic [CntW-1:0]         wr_idx_q;
  logic [CntW-1:0]         pos_q;

  // pending result and output register
  logic                    res_flag_q;
  logic [OutTagW-1:0]      res_tag_q;
  wprq_pkg::status_e       res_status_q;
  logic                    out_vld_q;
  wprq_pkg::out_item_t     out_q;

  // memory
  entry_t                  mem_q [QUEUE_DEPTH];
  entry_t                  rdata_q;
  entry_t                  wdata;
  logic                    mem_re, mem_we;
  logic [PtrW-1:0]         rd_addr, wr_addr;

  logic                    div_start, div_done;
  logic [BucketW-1:0]      div_quot;

  logic [CntW-1:0]         last_idx;
  logic [BucketW:0]        diff;
  logic                    add_hit, rm_hit, scan_hit, is_add;
  logic [PtrW-1:0]         head_next;

  // Map a position in the queue to a memory slot, wrapping past the end.
  function automatic logic [PtrW-1:0] phys(input logic [PtrW-1:0] head,
                                           input logic [CntW-1:0] idx);
    logic [SumW-1:0] sum;
    sum = SumW'(head) + SumW'(idx);
    if (sum >= SumW'(QUEUE_DEPTH)) begin
      sum = sum - SumW'(QUEUE_DEPTH);
    end
    return sum[PtrW-1:0];
  endfunction

  wprq_bucket_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_item_i.arrival_time),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Start the bucket divide as soon as an add is taken into a queue with room.
  assign div_start = (state_q == S_IDLE) && in_valid_i &&
                     (in_item_i.mode == wprq_pkg::MODE_ADD) && (count_q != DepthCnt);

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  assign last_idx  = count_q - 1'b1;
  assign head_next = (head_q == LastPtr) ? '0 : head_q + 1'b1;
  assign is_add    = (mode_q == wprq_pkg::MODE_ADD);

  // Insert test against the entry just read: an unsigned bucket difference
  // that wraps (entry newer than the newcomer) is outside the window.
  assign diff     = {1'b0, new_bucket_q} - {1'b0, rdata_q.bucket};
  assign add_hit  = !diff[BucketW] && (diff[BucketW-1:0] <= BucketW'(window_q)) &&
                    (new_runtime_q <= rdata_q.runtime);
  assign rm_hit   = (rdata_q.tag == new_tag_q);
  assign scan_hit = is_add ? add_hit : rm_hit;

  // Memory port control
  always_comb begin
    mem_re  = 1'b0;
    mem_we  = 1'b0;
    rd_addr = phys(head_q, rd_idx_q);
    wr_addr = phys(head_q, wr_idx_q);
    wdata   = rdata_q;
    case (state_q)
      S_SCAN: begin
        mem_re = rd_act_q;
      end
      S_SHIFT: begin
        // read one slot ahead, write back what came out last cycle
        mem_re = rd_act_q;
        mem_we = dv_q;
      end
      S_INS: begin
        mem_we  = 1'b1;
        wr_addr = phys(head_q, pos_q);
        wdata   = '{tag: new_tag_q, runtime: new_runtime_q, bucket: new_bucket_q};
      end
      S_POP: begin
        mem_re  = 1'b1;
        rd_addr = head_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      head_q        <= '0;
      window_q      <= wprq_pkg::WindowReset;
      out_vld_q     <= 1'b0;
      rd_act_q      <= 1'b0;
      dv_q          <= 1'b0;
      mode_q        <= wprq_pkg::MODE_NOP;
      new_tag_q     <= '0;
      new_runtime_q <= '0;
      new_bucket_q  <= '0;
      rd_idx_q      <= '0;
      chk_idx_q     <= '0;
      wr_idx_q      <= '0;
      pos_q         <= '0;
      out_q         <= '0;
      res_flag_q    <= 1'b0;
      res_tag_q     <= '0;
      res_status_q  <= wprq_pkg::STATUS_OK;
    end else begin
      if (cfg_valid_i) begin
        window_q <= cfg_data_i;
      end
      if (out_vld_q && out_ready_i) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            mode_q        <= in_item_i.mode;
            new_tag_q     <= in_item_i.request_tag[StTagW-1:0];
            new_runtime_q <= in_item_i.virtual_runtime;
            res_flag_q    <= 1'b0;
            res_tag_q     <= '0;
            res_status_q  <= wprq_pkg::STATUS_OK;
            case (in_item_i.mode)
              wprq_pkg::MODE_ADD: begin
                if (count_q == DepthCnt) begin
                  res_status_q <= wprq_pkg::STATUS_FULL;
                  state_q      <= S_DONE;
                end else begin
                  state_q <= S_DIV;
                end
              end
              wprq_pkg::MODE_DISPATCH: begin
                if (count_q == '0) begin
                  res_status_q <= wprq_pkg::STATUS_MISS;
                  state_q      <= S_DONE;
                end else begin
                  state_q <= S_POP;
                end
              end
              wprq_pkg::MODE_REMOVE: begin
                if (count_q == '0) begin
                  res_status_q <= wprq_pkg::STATUS_MISS;
                  state_q      <= S_DONE;
                end else begin
                  rd_idx_q <= '0;
                  rd_act_q <= 1'b1;
                  dv_q     <= 1'b0;
                  state_q  <= S_SCAN;
                end
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end

        S_DIV: begin
          if (div_done) begin
            new_bucket_q <= div_quot;
            if (count_q <= CntW'(1)) begin
              // nothing to walk past: append
              pos_q   <= count_q;
              state_q <= S_INS;
            end else begin
              rd_idx_q <= CntW'(1);
              rd_act_q <= 1'b1;
              dv_q     <= 1'b0;
              state_q  <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          // issue the next read and test the entry read last cycle
          if (rd_act_q) begin
            rd_idx_q <= rd_idx_q + 1'b1;
            rd_act_q <= (rd_idx_q != last_idx);
          end
          dv_q      <= rd_act_q;
          chk_idx_q <= rd_idx_q;
          if (dv_q) begin
            if (scan_hit) begin
              pos_q <= chk_idx_q;
              if (is_add) begin
                // open the slot from the tail down
                rd_idx_q <= last_idx;
                rd_act_q <= 1'b1;
                dv_q     <= 1'b0;
                state_q  <= S_SHIFT;
              end else if (chk_idx_q == last_idx) begin
                count_q <= count_q - 1'b1;
                state_q <= S_DONE;
              end else begin
                // close the gap from the hit upward
                rd_idx_q <= chk_idx_q + 1'b1;
                rd_act_q <= 1'b1;
                dv_q     <= 1'b0;
                state_q  <= S_SHIFT;
              end
            end else if (chk_idx_q == last_idx) begin
              if (is_add) begin
                pos_q   <= count_q;
                state_q <= S_INS;
              end else begin
                res_status_q <= wprq_pkg::STATUS_MISS;
                state_q      <= S_DONE;
              end
            end
          end
        end

        S_SHIFT: begin
          if (rd_act_q) begin
            wr_idx_q <= is_add ? rd_idx_q + 1'b1 : rd_idx_q - 1'b1;
            if (rd_idx_q == (is_add ? pos_q : last_idx)) begin
              rd_act_q <= 1'b0;
            end else begin
              rd_idx_q <= is_add ? rd_idx_q - 1'b1 : rd_idx_q + 1'b1;
            end
          end
          dv_q <= rd_act_q;
          if (!rd_act_q && dv_q) begin
            if (is_add) begin
              state_q <= S_INS;
            end else begin
              count_q <= count_q - 1'b1;
              state_q <= S_DONE;
            end
          end
        end

        S_INS: begin
          count_q <= count_q + 1'b1;
          state_q <= S_DONE;
        end

        S_POP: begin
          state_q <= S_POPD;
        end

        S_POPD: begin
          res_flag_q <= 1'b1;
          res_tag_q  <= OutTagW'(rdata_q.tag);
          head_q     <= head_next;
          count_q    <= count_q - 1'b1;
          state_q    <= S_DONE;
        end

        S_DONE: begin
          // hold until the output register is free
          if (!out_vld_q || out_ready_i) begin
            out_q.out_valid <= res_flag_q;
            out_q.out_tag   <= res_tag_q;
            out_q.status    <= res_status_q;
            out_q.occupancy <= OccW'(count_q);
            out_vld_q       <= 1'b1;
            state_q         <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt)
    else $error("fill count beyond queue depth");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we)
    else $error("memory written while idle");

  a_dispatch_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.out_valid) |-> (out_item_o.status == wprq_pkg::STATUS_OK))
    else $error("dispatched item carries an error status");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("accepted item did not start an operation");

endmodule

// ===== design/wprq_bucket_div.sv =====
// ----------------------------------------------------------------------------
// wprq_bucket_div
// Iterative divide of a 64-bit arrival time by the bucket size, several
// quotient bits per cycle; done_o pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module wprq_bucket_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [wprq_pkg::ArrW-1:0]        dividend_i,
  output logic                             done_o,
  output logic [wprq_pkg::BucketW-1:0]     quotient_o
);

  localparam int ArrW   = wprq_pkg::ArrW;
  localparam int RemW   = wprq_pkg::RemW;
  localparam int Steps  = wprq_pkg::DivStepBits;
  localparam int Cycles = ArrW / Steps;
  localparam int CntW   = $clog2(Cycles);
  localparam logic [RemW:0]   Divisor  = (RemW+1)'(wprq_pkg::BucketDiv);
  localparam logic [CntW-1:0] LastStep = CntW'(Cycles - 1);

  logic            active_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [ArrW-1:0] work_q, work_d;
  logic [RemW-1:0] rem_q, rem_d;

  // Restoring division: shift the dividend out at the top, quotient bits in
  // at the bottom.
  always_comb begin
    logic [ArrW-1:0] w;
    logic [RemW-1:0] r;
    logic [RemW:0]   t;
    w = work_q;
    r = rem_q;
    for (int i = 0; i < Steps; i++) begin
      t = {r, w[ArrW-1]};
      w = {w[ArrW-2:0], 1'b0};
      if (t >= Divisor) begin
        t    = t - Divisor;
        w[0] = 1'b1;
      end
      r = t[RemW-1:0];
    end
    work_d = w;
    rem_d  = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= dividend_i;
      rem_q  <= '0;
    end else if (active_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = work_q[wprq_pkg::BucketW-1:0];

endmodule
